FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the checker file ift_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define IFT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define IFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ift_pkg.sv
// ----------------------------------------------------------------------------
// ift_pkg
// Types, codes and constants of the IPv4 fragment tracker.
// ----------------------------------------------------------------------------
package ift_pkg;

    typedef struct packed {
        logic        is_ipv4;
        logic [3:0]  header_words;
        logic [15:0] frag_ctrl;
        logic [15:0] ident;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] packet_length;
        logic [63:0] now_ns;
    } hdr_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic        complete;
        logic [31:0] buffer_id;
        logic [15:0] offset_bytes;
        logic [15:0] data_size;
        logic [4:0]  fragment_total;
        logic [16:0] reassembled_len;
        logic [31:0] alert_src;
        logic [31:0] alert_dst;
        logic [7:0]  alert_protocol;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] ident;
        logic [7:0]  proto;
    } stream_key_t;

    typedef struct packed {
        logic [31:0] buffer_id;
        logic [15:0] offset_bytes;
        logic [15:0] data_size;
    } frag_rec_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAIN,
        S_HASH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_COMMIT,
        S_FLUSH_RD,
        S_FLUSH_OUT
    } fsm_t;

    typedef enum logic [1:0] {
        AGE_NONE,
        AGE_TOUCH,
        AGE_FLUSH
    } age_op_t;

    localparam int          CFG_IDX_W      = 1;
    localparam logic        CFG_TIMEOUT    = 1'b0;
    localparam logic        CFG_MAX_FRAG   = 1'b1;

    localparam logic [2:0]  STAT_NOT_FRAG  = 3'd0;
    localparam logic [2:0]  STAT_NEW       = 3'd1;
    localparam logic [2:0]  STAT_APPEND    = 3'd2;
    localparam logic [2:0]  STAT_FULL      = 3'd3;
    localparam logic [2:0]  STAT_TIMEOUT   = 3'd4;

    localparam logic        KIND_VERDICT   = 1'b0;
    localparam logic        KIND_RELEASE   = 1'b1;

    localparam logic [63:0] TIMEOUT_RESET  = 64'd30000000000;
    localparam logic [15:0] MAX_FRAG_RESET = 16'hFFFF;
    localparam logic [31:0] HASH_MULT      = 32'h045D9F3B;
    localparam int          MF_BIT         = 13;

    // Stream hash: rotated addresses, multiplied ident and shifted protocol.
    function automatic logic [31:0] stream_hash(input hdr_t h);
        logic [31:0] prod;
        prod = 32'({16'h0000, h.ident} * HASH_MULT);
        return {h.src_addr[16:0], h.src_addr[31:17]}
             ^ {h.dst_addr[24:0], h.dst_addr[31:25]}
             ^ prod
             ^ {8'h00, h.protocol, 16'h0000};
    endfunction

endpackage

FILE: hw/rtl/ift_lru_ages.sv
// ----------------------------------------------------------------------------
// ift_lru_ages
// Valid bits and LRU ages of the stream table.
// ----------------------------------------------------------------------------
module ift_lru_ages #(
    parameter int ENTRIES = 16,
    parameter int IW      = 4,
    parameter int AW      = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ift_pkg::age_op_t            op,
    input  logic [IW-1:0]               idx,
    input  logic [AW-1:0]               ref_age,
    output logic [ENTRIES-1:0]          valid,
    output logic [ENTRIES-1:0][AW-1:0]  ages
);
    import ift_pkg::*;

    logic [ENTRIES-1:0]         valid_reg, valid_next;
    logic [ENTRIES-1:0][AW-1:0] age_reg, age_next;

    always_comb
    begin
        valid_next = valid_reg;
        age_next   = age_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            unique case (op)
                AGE_TOUCH:
                begin
                    if (i == int'(idx))
                    begin
                        valid_next[i] = 1'b1;
                        age_next[i]   = '0;
                    end
                    else if (valid_reg[i] && age_reg[i] < ref_age)
                    begin
                        age_next[i] = age_reg[i] + AW'(1);
                    end
                end
                // touch followed by release of the entry, in one step
                AGE_FLUSH:
                begin
                    if (i == int'(idx))
                    begin
                        valid_next[i] = 1'b0;
                        age_next[i]   = '0;
                    end
                    else if (valid_reg[i] && age_reg[i] >= ref_age && age_reg[i] != '0)
                    begin
                        age_next[i] = age_reg[i] - AW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            age_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
        end
    end

    assign valid = valid_reg;
    assign ages  = age_reg;

endmodule

FILE: hw/rtl/ipv4_fragment_tracker.sv
// ----------------------------------------------------------------------------
// ipv4_fragment_tracker
// LRU table of IPv4 fragment streams with completion and release reports.
// ----------------------------------------------------------------------------
// One header per start beat. A non-fragment goes through S_PLAIN; a fragment
// through S_HASH, S_SCAN_RD and S_SCAN_CMP per entry scanned (the first
// match, or all STREAM_ENTRIES on a miss) and S_COMMIT: the key memory has a
// single read port and the table is searched one entry at a time. A flush
// reads and shows the released buffers one at a time from the fragment memory.
// Results come one per strobe and cannot be held off; busy drops in the cycle
// that shows the last result of a header, and start may be given in that cycle.
module ipv4_fragment_tracker #(
    parameter int STREAM_ENTRIES   = 16,
    parameter int FRAGS_PER_STREAM = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ift_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_wdata,
    input  logic                          start,
    input  ift_pkg::hdr_t                 request,
    output logic                          busy,
    output logic                          result_valid,
    output ift_pkg::result_t              result
);
    import ift_pkg::*;

    localparam int IW  = (STREAM_ENTRIES > 1) ? $clog2(STREAM_ENTRIES) : 1;
    localparam int FD  = STREAM_ENTRIES * FRAGS_PER_STREAM;
    localparam int FAW = (FD > 1) ? $clog2(FD) : 1;
    localparam int CW  = $clog2(FRAGS_PER_STREAM + 1);
    localparam int AW  = $clog2(STREAM_ENTRIES + 1);

    // memories
    stream_key_t  key_mem  [STREAM_ENTRIES];
    logic [63:0]  seen_mem [STREAM_ENTRIES];
    logic [CW-1:0] cnt_mem [STREAM_ENTRIES];
    frag_rec_t    frag_mem [FD];

    stream_key_t  key_rd_reg;
    logic [63:0]  seen_rd_reg;
    logic [CW-1:0] cnt_rd_reg;
    frag_rec_t    frag_rd_reg;

    logic          key_re, key_we, frag_re, frag_we;
    logic [IW-1:0] key_waddr;
    stream_key_t   key_wkey;
    logic [63:0]   key_wseen;
    logic [CW-1:0] key_wcnt;
    logic [FAW-1:0] frag_waddr, frag_raddr;
    frag_rec_t     frag_wdata;

    // control
    fsm_t          state_reg, state_next;
    logic [63:0]   timeout_reg;
    logic [15:0]   max_frag_reg;
    logic [IW-1:0] scan_idx_reg, scan_idx_next;
    logic          hit_reg, hit_next;
    logic          free_found_reg, free_found_next;
    logic [CW-1:0] flush_i_reg, flush_i_next;
    logic [CW-1:0] flush_cnt_reg, flush_cnt_next;
    logic          out_valid_reg, out_valid_next;

    // payload
    hdr_t          in_reg, in_next;
    logic [31:0]   hash_reg, hash_next;
    logic [15:0]   dlen_reg, dlen_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [AW-1:0] age_e_reg, age_e_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [IW-1:0] oldest_idx_reg, oldest_idx_next;
    logic [AW-1:0] oldest_age_reg, oldest_age_next;
    logic [FAW-1:0] flush_base_reg, flush_base_next;
    result_t       out_reg, out_next;

    // age table
    age_op_t                     age_op;
    logic [IW-1:0]               age_idx;
    logic [AW-1:0]               age_ref;
    logic [STREAM_ENTRIES-1:0]   valid_vec;
    logic [STREAM_ENTRIES-1:0][AW-1:0] ages;

    ift_lru_ages #(
        .ENTRIES (STREAM_ENTRIES),
        .IW      (IW),
        .AW      (AW)
    ) u_ages (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (age_op),
        .idx     (age_idx),
        .ref_age (age_ref),
        .valid   (valid_vec),
        .ages    (ages)
    );

    // derived header values
    stream_key_t   in_key;
    logic [12:0]   off_units;
    logic          mf;
    logic [15:0]   off_bytes;
    logic [15:0]   hdr_bytes;
    logic [15:0]   plen_diff;
    logic          timed_out;
    logic [IW-1:0] victim;
    logic [FAW-1:0] hit_base;
    logic [CW-1:0] fcnt;
    logic [31:0]   bid;

    assign in_key    = '{src: in_reg.src_addr, dst: in_reg.dst_addr,
                         ident: in_reg.ident, proto: in_reg.protocol};
    assign off_units = in_reg.frag_ctrl[12:0];
    assign mf        = in_reg.frag_ctrl[MF_BIT];
    assign off_bytes = {off_units, 3'b000};
    assign hdr_bytes = {10'd0, in_reg.header_words, 2'b00};
    assign plen_diff = in_reg.packet_length - hdr_bytes;
    assign timed_out = (in_reg.now_ns - seen_rd_reg) > timeout_reg;
    assign victim    = free_found_reg ? free_idx_reg : oldest_idx_reg;
    assign hit_base  = FAW'(hit_idx_reg) * FAW'(FRAGS_PER_STREAM);
    assign frag_raddr = flush_base_reg + FAW'(flush_i_reg);

    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        flush_i_next    = flush_i_reg;
        flush_cnt_next  = flush_cnt_reg;
        out_valid_next  = 1'b0;
        in_next         = in_reg;
        hash_next       = hash_reg;
        dlen_next       = dlen_reg;
        hit_idx_next    = hit_idx_reg;
        age_e_next      = age_e_reg;
        free_idx_next   = free_idx_reg;
        oldest_idx_next = oldest_idx_reg;
        oldest_age_next = oldest_age_reg;
        flush_base_next = flush_base_reg;
        out_next        = out_reg;
        key_re          = 1'b0;
        key_we          = 1'b0;
        key_waddr       = hit_idx_reg;
        key_wkey        = in_key;
        key_wseen       = in_reg.now_ns;
        key_wcnt        = CW'(1);
        frag_re         = 1'b0;
        frag_we         = 1'b0;
        frag_waddr      = hit_base;
        frag_wdata      = '{buffer_id: '0, offset_bytes: off_bytes, data_size: dlen_reg};
        age_op          = AGE_NONE;
        age_idx         = hit_idx_reg;
        age_ref         = age_e_reg;
        fcnt            = cnt_rd_reg;
        bid             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    in_next = request;
                    if (request.is_ipv4 &&
                        (request.frag_ctrl[12:0] != '0 || request.frag_ctrl[MF_BIT]))
                        state_next = S_HASH;
                    else
                        state_next = S_PLAIN;
                end
            end
            S_PLAIN:
            begin
                out_next        = '0;
                out_next.status = STAT_NOT_FRAG;
                out_next.last   = 1'b1;
                out_valid_next  = 1'b1;
                state_next      = S_IDLE;
            end
            S_HASH:
            begin
                hash_next = stream_hash(in_reg);
                // short packets wrap to a huge length and hit the cap
                if (in_reg.packet_length < hdr_bytes || plen_diff > max_frag_reg)
                    dlen_next = max_frag_reg;
                else
                    dlen_next = plen_diff;
                scan_idx_next   = '0;
                hit_next        = 1'b0;
                free_found_next = 1'b0;
                state_next      = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                key_re     = 1'b1;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (valid_vec[scan_idx_reg] && key_rd_reg == in_key)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = scan_idx_reg;
                    age_e_next   = ages[scan_idx_reg];
                    state_next   = S_COMMIT;
                end
                else
                begin
                    if (!valid_vec[scan_idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = scan_idx_reg;
                    end
                    if (scan_idx_reg == '0 || ages[scan_idx_reg] > oldest_age_reg)
                    begin
                        oldest_idx_next = scan_idx_reg;
                        oldest_age_next = ages[scan_idx_reg];
                    end
                    if (scan_idx_reg == IW'(STREAM_ENTRIES - 1))
                    begin
                        state_next = S_COMMIT;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + IW'(1);
                        state_next    = S_SCAN_RD;
                    end
                end
            end
            S_COMMIT:
            begin
                out_next       = '0;
                out_valid_next = 1'b1;
                if (!hit_reg)
                begin
                    bid        = hash_reg ^ {3'b000, off_units, 16'h0000};
                    key_we     = 1'b1;
                    key_waddr  = victim;
                    frag_we    = 1'b1;
                    frag_waddr = FAW'(victim) * FAW'(FRAGS_PER_STREAM);
                    frag_wdata.buffer_id = bid;
                    age_op     = AGE_TOUCH;
                    age_idx    = victim;
                    age_ref    = AW'(STREAM_ENTRIES);
                    out_next.status       = STAT_NEW;
                    out_next.buffer_id    = bid;
                    out_next.offset_bytes = off_bytes;
                    out_next.data_size    = dlen_reg;
                    out_next.last         = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    if (timed_out)
                    begin
                        out_next.status = STAT_TIMEOUT;
                    end
                    else if (cnt_rd_reg < CW'(FRAGS_PER_STREAM))
                    begin
                        bid = hash_reg ^ ({3'b000, off_units, 16'h0000} |
                                          (32'(cnt_rd_reg) << 8));
                        frag_we    = 1'b1;
                        frag_waddr = hit_base + FAW'(cnt_rd_reg);
                        frag_wdata.buffer_id = bid;
                        key_we    = 1'b1;
                        key_wkey  = key_rd_reg;
                        key_wseen = seen_rd_reg;
                        key_wcnt  = cnt_rd_reg + CW'(1);
                        fcnt      = cnt_rd_reg + CW'(1);
                        out_next.status       = STAT_APPEND;
                        out_next.buffer_id    = bid;
                        out_next.offset_bytes = off_bytes;
                        out_next.data_size    = dlen_reg;
                    end
                    else
                    begin
                        out_next.status = STAT_FULL;
                    end

                    if (!timed_out && mf)
                    begin
                        age_op        = AGE_TOUCH;
                        out_next.last = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        age_op = AGE_FLUSH;
                        if (!timed_out)
                        begin
                            out_next.complete        = 1'b1;
                            out_next.reassembled_len = 17'(off_bytes) +
                                17'(in_reg.packet_length) - 17'(hdr_bytes);
                        end
                        out_next.fragment_total = 5'(fcnt);
                        out_next.alert_src      = key_rd_reg.src;
                        out_next.alert_dst      = key_rd_reg.dst;
                        out_next.alert_protocol = key_rd_reg.proto;
                        out_next.last           = (fcnt == '0);
                        flush_cnt_next  = fcnt;
                        flush_i_next    = '0;
                        flush_base_next = hit_base;
                        state_next      = (fcnt == '0) ? S_IDLE : S_FLUSH_RD;
                    end
                end
            end
            S_FLUSH_RD:
            begin
                frag_re    = 1'b1;
                state_next = S_FLUSH_OUT;
            end
            S_FLUSH_OUT:
            begin
                out_next              = '0;
                out_next.kind         = KIND_RELEASE;
                out_next.buffer_id    = frag_rd_reg.buffer_id;
                out_next.offset_bytes = frag_rd_reg.offset_bytes;
                out_next.data_size    = frag_rd_reg.data_size;
                out_next.last         = (flush_i_reg == flush_cnt_reg - CW'(1));
                out_valid_next        = 1'b1;
                if (flush_i_reg == flush_cnt_reg - CW'(1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    flush_i_next = flush_i_reg + CW'(1);
                    state_next   = S_FLUSH_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            timeout_reg    <= TIMEOUT_RESET;
            max_frag_reg   <= MAX_FRAG_RESET;
            scan_idx_reg   <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            flush_i_reg    <= '0;
            flush_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            flush_i_reg    <= flush_i_next;
            flush_cnt_reg  <= flush_cnt_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_TIMEOUT:  timeout_reg  <= cfg_wdata;
                    CFG_MAX_FRAG: max_frag_reg <= cfg_wdata[15:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg         <= in_next;
        hash_reg       <= hash_next;
        dlen_reg       <= dlen_next;
        hit_idx_reg    <= hit_idx_next;
        age_e_reg      <= age_e_next;
        free_idx_reg   <= free_idx_next;
        oldest_idx_reg <= oldest_idx_next;
        oldest_age_reg <= oldest_age_next;
        flush_base_reg <= flush_base_next;
        out_reg        <= out_next;
    end

    // stream record memory
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr]  <= key_wkey;
            seen_mem[key_waddr] <= key_wseen;
            cnt_mem[key_waddr]  <= key_wcnt;
        end
        if (key_re)
        begin
            key_rd_reg  <= key_mem[scan_idx_reg];
            seen_rd_reg <= seen_mem[scan_idx_reg];
            cnt_rd_reg  <= cnt_mem[scan_idx_reg];
        end
    end

    // fragment record memory
    always_ff @(posedge clk)
    begin
        if (frag_we)
            frag_mem[frag_waddr] <= frag_wdata;
        if (frag_re)
            frag_rd_reg <= frag_mem[frag_raddr];
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: hw/rtl/ift_checker.sv
// ----------------------------------------------------------------------------
// ift_checker
// Port-level checks of the fragment tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ift_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             result_valid,
    input ift_pkg::result_t result
);
    import ift_pkg::*;

    // an accepted header makes the block busy, with no result yet, in the cycle after
    `IFT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !result_valid, "no busy after accept")
    // the final beat of a header frees the block
    `IFT_ASSERT(a_last_idle, clk, rst_n, result_valid && result.last |-> !busy, "busy on last beat")
    `IFT_ASSERT(a_mid_busy, clk, rst_n, result_valid && !result.last |-> busy, "idle before last beat")
    `IFT_ASSERT(a_fell_last, clk, rst_n, $fell(busy) |-> result_valid && result.last, "busy fell without last beat")

endmodule

bind ipv4_fragment_tracker ift_checker u_ift_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
